FILE: hw/rtl/servo_duty_slew_limiter_assert.svh
// Assertion helpers used by svdsl_back.
`ifndef SERVO_DUTY_SLEW_LIMITER_ASSERT_SVH
`define SERVO_DUTY_SLEW_LIMITER_ASSERT_SVH

// Same-cycle implication.
`define SVDSL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SVDSL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/svdsl_pkg.sv
`default_nettype none

package svdsl_pkg;

   // item field widths
   localparam int ACTION_W  = 1;
   localparam int ELAPSED_W = 20;
   localparam int DIR_W     = 2;
   localparam int RATE_W    = 20;
   localparam int DUTY_W    = 25;

   // register widths
   localparam int TMIN_W  = 24;
   localparam int GAIN_W  = 24;
   localparam int FMODE_W = 3;
   localparam int FANG_W  = 9;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   localparam logic [CSR_INDEX_W-1:0] CSR_UPDATE_TIME_MIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_SPEED   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_MIN        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_MAX        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_GAIN      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE_MODE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE_ANGLE     = 3'd6;

   // register reset values
   localparam logic [TMIN_W-1:0]  TMIN_RESET     = 24'd20000;
   localparam logic [RATE_W-1:0]  SPEED_RESET    = 20'd65536;
   localparam logic [DUTY_W-1:0]  DUTY_MIN_RESET = 25'd1000000;
   localparam logic [DUTY_W-1:0]  DUTY_MAX_RESET = 25'd2000000;
   localparam logic [GAIN_W-1:0]  GAIN_RESET     = 24'd1422222;

   // input codes
   localparam logic [ACTION_W-1:0] ACT_HOME = 1'b0;
   localparam logic [DIR_W-1:0]    DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0]    DIR_DOWN = 2'd2;

   // force modes
   localparam logic [FMODE_W-1:0] FM_UP    = 3'd1;
   localparam logic [FMODE_W-1:0] FM_DOWN  = 3'd2;
   localparam logic [FMODE_W-1:0] FM_HOLD  = 3'd3;
   localparam logic [FMODE_W-1:0] FM_ANGLE = 3'd4;

   // classified operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_HOME  = 3'd0;
   localparam logic [OP_W-1:0] OP_KEEP  = 3'd1;
   localparam logic [OP_W-1:0] OP_DEC   = 3'd2;
   localparam logic [OP_W-1:0] OP_INC   = 3'd3;
   localparam logic [OP_W-1:0] OP_ANGLE = 3'd4;

   // angle to duty arithmetic
   localparam int AMAG_W      = 9;
   localparam int ADIFF_W     = 11;
   localparam int GAIN_FRAC   = 8;
   localparam int AP_W        = AMAG_W + GAIN_W + 1;
   localparam int AR_W        = AP_W - GAIN_FRAC;
   localparam int ANGLE_NXT_W = AR_W + 2;
   localparam logic [AMAG_W-1:0]         HOME_DIFF  = 9'd90;
   localparam logic signed [ADIFF_W-1:0] FORCE_BIAS = 11'sd110;
   localparam logic [AP_W-1:0]           GAIN_HALF  = 34'd128;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [TMIN_W-1:0]        update_time_min_us;
      logic [RATE_W-1:0]        default_speed;
      logic [DUTY_W-1:0]        duty_min_ns;
      logic [DUTY_W-1:0]        duty_max_ns;
      logic [GAIN_W-1:0]        angle_gain;
      logic [FMODE_W-1:0]       force_mode;
      logic signed [FANG_W-1:0] force_angle_deg;
   } svdsl_cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [ELAPSED_W-1:0] elapsed;
      logic [RATE_W-1:0]    speed;
   } svdsl_entry_type;

endpackage

`default_nettype wire

FILE: hw/rtl/svdsl_chan_if.sv
`default_nettype none

interface svdsl_req_chan;
   logic                            valid;
   logic                            ready;
   logic [svdsl_pkg::ACTION_W-1:0]  action;
   logic [svdsl_pkg::ELAPSED_W-1:0] elapsed_us;
   logic [svdsl_pkg::DIR_W-1:0]     move_direction;
   logic [svdsl_pkg::RATE_W-1:0]    move_rate;

   modport source (output valid, action, elapsed_us, move_direction, move_rate,
                   input ready);
   modport sink (input valid, action, elapsed_us, move_direction, move_rate,
                 output ready);
endinterface

interface svdsl_rsp_chan;
   logic                         valid;
   logic                         ready;
   logic [svdsl_pkg::DUTY_W-1:0] duty_ns;

   modport source (output valid, duty_ns, input ready);
   modport sink (input valid, duty_ns, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/servo_duty_slew_limiter.sv
// Servo duty slew limiter.
// req_if takes items (valid/ready): action 0 homes the servo, action 1 is a
// time tick carrying elapsed_us, move_direction and move_rate. rsp_if gives
// duty_ns items (valid/ready). A home always yields one item; a tick yields
// one only when the accumulated time reaches update_time_min_us and the
// clamped duty changes. csr_we/csr_index/csr_wdata write the seven
// registers; write them only while no item is in flight.
// A home or a tick that moves the duty passes from the idle state through a
// multiply state, an add state and the clamp step into the output register;
// a tick below the time threshold retires in the idle state. The back-end
// sequencer takes a new item only in idle, after its clamp step if any.
// A 2-entry queue in front keeps req_if ready while the back end works.
// Reset (synchronous, active high) loads the register defaults, clears the
// time accumulator, sets the duty to the default minimum and empties the
// queue. When the receiver stalls, the result is held in the output register
// and the sequencer waits in its clamp step; the queue keeps filling.
`default_nettype none

module servo_duty_slew_limiter #(
   parameter int DUTY_BITS       = 25,
   parameter int SPEED_FRAC_BITS = 16,
   parameter int TIME_BITS       = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   svdsl_req_chan.sink                          req_if,
   svdsl_rsp_chan.source                        rsp_if,
   input  wire                                  csr_we,
   input  wire [svdsl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [svdsl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import svdsl_pkg::*;

   svdsl_cfg_type   cfg_ff, cfg_in;
   logic            q_valid;
   svdsl_entry_type q_entry;
   logic            q_pop;

   // register file: decode index, truncate data to the register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_UPDATE_TIME_MIN: cfg_in.update_time_min_us = csr_wdata[TMIN_W-1:0];
            CSR_DEFAULT_SPEED:   cfg_in.default_speed      = csr_wdata[RATE_W-1:0];
            CSR_DUTY_MIN:        cfg_in.duty_min_ns        = csr_wdata[DUTY_W-1:0];
            CSR_DUTY_MAX:        cfg_in.duty_max_ns        = csr_wdata[DUTY_W-1:0];
            CSR_ANGLE_GAIN:      cfg_in.angle_gain         = csr_wdata[GAIN_W-1:0];
            CSR_FORCE_MODE:      cfg_in.force_mode         = csr_wdata[FMODE_W-1:0];
            CSR_FORCE_ANGLE:     cfg_in.force_angle_deg    = signed'(csr_wdata[FANG_W-1:0]);
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.update_time_min_us <= TMIN_RESET;
         cfg_ff.default_speed      <= SPEED_RESET;
         cfg_ff.duty_min_ns        <= DUTY_MIN_RESET;
         cfg_ff.duty_max_ns        <= DUTY_MAX_RESET;
         cfg_ff.angle_gain         <= GAIN_RESET;
         cfg_ff.force_mode         <= '0;
         cfg_ff.force_angle_deg    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, classify, queue
   svdsl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_if  (req_if),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   // back: accumulate time, compute the step, clamp, emit
   svdsl_back #(
      .DUTY_BITS       (DUTY_BITS),
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
      .TIME_BITS       (TIME_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/svdsl_front.sv
`default_nettype none

module svdsl_front (
   input  wire                        clock,
   input  wire                        reset,
   input  svdsl_pkg::svdsl_cfg_type   cfg,
   svdsl_req_chan.sink                req_if,
   output logic                       q_valid,
   output svdsl_pkg::svdsl_entry_type q_entry,
   input  wire                        q_pop
);
   import svdsl_pkg::*;

   svdsl_entry_type    entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   svdsl_entry_type    cls;
   logic               push;

   // classify: resolve speed and fold force mode and direction into one op
   always_comb begin
      cls.elapsed = req_if.elapsed_us;
      cls.speed   = (req_if.move_rate == '0) ? cfg.default_speed : req_if.move_rate;
      if (req_if.action == ACT_HOME) begin
         cls.op = OP_HOME;
      end else begin
         case (cfg.force_mode)
            FM_UP:    cls.op = OP_INC;
            FM_DOWN:  cls.op = OP_DEC;
            FM_HOLD:  cls.op = OP_KEEP;
            FM_ANGLE: cls.op = OP_ANGLE;
            default: begin
               case (req_if.move_direction)
                  DIR_UP:   cls.op = OP_DEC;
                  DIR_DOWN: cls.op = OP_INC;
                  default:  cls.op = OP_KEEP;
               endcase
            end
         endcase
      end
   end

   assign req_if.ready = (count_ff != QCNT_W'(QDEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign q_valid      = (count_ff != '0);
   assign q_entry      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/svdsl_back.sv
`default_nettype none

`include "servo_duty_slew_limiter_assert.svh"

module svdsl_back #(
   parameter int DUTY_BITS       = 25,
   parameter int SPEED_FRAC_BITS = 16,
   parameter int TIME_BITS       = 24
) (
   input  wire                        clock,
   input  wire                        reset,
   input  svdsl_pkg::svdsl_cfg_type   cfg,
   input  wire                        q_valid,
   input  svdsl_pkg::svdsl_entry_type q_entry,
   output logic                       q_pop,
   svdsl_rsp_chan.source              rsp_if
);
   import svdsl_pkg::*;

   localparam int PROD_W  = RATE_W + TIME_BITS + 1;
   localparam int DELTA_W = PROD_W - SPEED_FRAC_BITS;
   localparam int NB0     = (DUTY_BITS + 1 > DELTA_W) ? DUTY_BITS + 1 : DELTA_W;
   localparam int NXT_W   = (NB0 + 2 > ANGLE_NXT_W) ? NB0 + 2 : ANGLE_NXT_W;
   localparam int ACC_W   = ((TIME_BITS > TMIN_W) ? TIME_BITS : TMIN_W) + 1;
   localparam logic [ACC_W-1:0]  TIME_MAX   = ACC_W'((64'd1 << TIME_BITS) - 64'd1);
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (SPEED_FRAC_BITS - 1));
   localparam logic [DUTY_BITS-1:0] DUTY_RESET = DUTY_BITS'(DUTY_MIN_RESET);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SMUL  = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_AMUL  = 3'd3;
   localparam logic [2:0] ST_AADD  = 3'd4;
   localparam logic [2:0] ST_CLAMP = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [RATE_W-1:0]       speed_ff, speed_in;
   logic [TIME_BITS-1:0]    t_ff, t_in;
   logic [DELTA_W-1:0]      delta_ff, delta_in;
   logic [AMAG_W-1:0]       mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [AR_W-1:0]         r_ff, r_in;
   logic signed [NXT_W-1:0] nxt_ff, nxt_in;
   logic [TIME_BITS-1:0]    time_accum_ff, time_accum_in;
   logic [DUTY_BITS-1:0]    duty_now_ff, duty_now_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]       rsp_duty_ff, rsp_duty_in;

   logic [ACC_W-1:0]          acc_sum, acc_sat;
   logic                      below;
   logic signed [ADIFF_W-1:0] fdiff;
   logic [AMAG_W-1:0]         fmag;
   logic [PROD_W-1:0]         smul;
   logic [AP_W-1:0]           amul;
   logic signed [NXT_W-1:0]   cur_ext, delta_ext, r_ext, min_ext, max_ext;
   logic signed [NXT_W-1:0]   clamp_hi, clamped;
   logic                      emit, out_free;

   always_comb begin
      acc_sum   = ACC_W'(time_accum_ff) + ACC_W'(q_entry.elapsed);
      acc_sat   = (acc_sum > TIME_MAX) ? TIME_MAX : acc_sum;
      below     = acc_sat < ACC_W'(cfg.update_time_min_us);
      fdiff     = FORCE_BIAS - ADIFF_W'(cfg.force_angle_deg);
      fmag      = fdiff[ADIFF_W-1] ? AMAG_W'(-fdiff) : AMAG_W'(fdiff);
      smul      = PROD_W'(speed_ff) * PROD_W'(t_ff) + ROUND_HALF;
      amul      = AP_W'(mag_ff) * AP_W'(cfg.angle_gain) + GAIN_HALF;
      cur_ext   = signed'(NXT_W'(duty_now_ff));
      delta_ext = signed'(NXT_W'(delta_ff));
      r_ext     = signed'(NXT_W'(r_ff));
      min_ext   = signed'(NXT_W'(cfg.duty_min_ns));
      max_ext   = signed'(NXT_W'(cfg.duty_max_ns));
      // clamp to max first, then to min
      clamp_hi  = (nxt_ff > max_ext) ? max_ext : nxt_ff;
      clamped   = (clamp_hi < min_ext) ? min_ext : clamp_hi;
      emit      = (op_ff == OP_HOME) || (clamped != cur_ext);
      out_free  = !rsp_valid_ff || rsp_if.ready;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      speed_in      = speed_ff;
      t_in          = t_ff;
      delta_in      = delta_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      r_in          = r_ff;
      nxt_in        = nxt_ff;
      time_accum_in = time_accum_ff;
      duty_now_in   = duty_now_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_duty_in   = rsp_duty_ff;
      q_pop         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = q_entry.op;
               speed_in = q_entry.speed;
               if (q_entry.op == OP_HOME) begin
                  time_accum_in = '0;
                  mag_in        = HOME_DIFF;
                  neg_in        = 1'b0;
                  state_in      = ST_AMUL;
               end else if (below) begin
                  time_accum_in = acc_sat[TIME_BITS-1:0];
               end else begin
                  time_accum_in = '0;
                  t_in          = acc_sat[TIME_BITS-1:0];
                  if (q_entry.op == OP_ANGLE) begin
                     mag_in   = fmag;
                     neg_in   = fdiff[ADIFF_W-1];
                     state_in = ST_AMUL;
                  end else begin
                     state_in = ST_SMUL;
                  end
               end
            end
         end
         ST_SMUL: begin
            delta_in = smul[PROD_W-1:SPEED_FRAC_BITS];
            state_in = ST_STEP;
         end
         ST_STEP: begin
            case (op_ff)
               OP_INC:  nxt_in = cur_ext + delta_ext;
               OP_DEC:  nxt_in = cur_ext - delta_ext;
               default: nxt_in = cur_ext;
            endcase
            state_in = ST_CLAMP;
         end
         ST_AMUL: begin
            r_in     = amul[AP_W-1:GAIN_FRAC];
            state_in = ST_AADD;
         end
         ST_AADD: begin
            nxt_in   = (neg_ff ? -r_ext : r_ext) + min_ext;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (out_free || !emit) begin
               state_in = ST_IDLE;
               if (emit) begin
                  duty_now_in  = clamped[DUTY_BITS-1:0];
                  rsp_valid_in = 1'b1;
                  rsp_duty_in  = DUTY_W'(clamped[DUTY_BITS-1:0]);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_accum_ff <= '0;
         duty_now_ff   <= DUTY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_accum_ff <= time_accum_in;
         duty_now_ff   <= duty_now_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      speed_ff    <= speed_in;
      t_ff        <= t_in;
      delta_ff    <= delta_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      r_ff        <= r_in;
      nxt_ff      <= nxt_in;
      rsp_duty_ff <= rsp_duty_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.duty_ns = rsp_duty_ff;

   `SVDSL_ASSERT_NEXT(a_home_clears, clock, reset, q_pop && (q_entry.op == OP_HOME), time_accum_ff == '0, "home left time accumulated")
   `SVDSL_ASSERT_SAME(a_out_tracks, clock, reset, rsp_valid_ff, rsp_duty_ff == DUTY_W'(duty_now_ff), "pending item differs from duty")
   `SVDSL_ASSERT_NEXT(a_clamp_waits, clock, reset, (state_ff == ST_CLAMP) && emit && !out_free, (state_ff == ST_CLAMP) && $stable(nxt_ff), "result lost while output full")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import svdsl_pkg::*;

   // Codes the package leaves unnamed.
   localparam logic [ACTION_W-1:0]    ACT_TICK    = 1'b1;
   localparam logic [DIR_W-1:0]       DIR_STOP    = 2'd0;
   localparam logic [DIR_W-1:0]       DIR_SPARE   = 2'd3;
   localparam logic [FMODE_W-1:0]     FM_NONE     = 3'd0;
   localparam logic [FMODE_W-1:0]     FM_SPARE_LO = 3'd5;
   localparam logic [FMODE_W-1:0]     FM_SPARE_HI = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 3'd7;

   localparam int     CSR_SLOTS    = 1 << CSR_INDEX_W;
   localparam int     ELAPSED_MAX  = (1 << ELAPSED_W) - 1;
   localparam int     RATE_MAX     = (1 << RATE_W) - 1;
   localparam int     SPEED_FRAC   = 16;
   localparam longint TIME_SAT     = (longint'(1) << TMIN_W) - 1;
   localparam int     QUIET_CYCLES = 30;    // covers a full queue of ticks that emit nothing
   localparam int     DRAIN_LIMIT  = 20000;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     RANDOM_PER_CFG = 54;

   typedef logic [CSR_DATA_W-1:0] csr_word_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [ELAPSED_W-1:0] elapsed;
      logic [DIR_W-1:0]     dir;
      logic [RATE_W-1:0]    rate;
   } servo_item_type;

   typedef enum int {
      CFG_DEFAULT, CFG_FAST, CFG_SLOW, CFG_SCRAMBLED, CFG_FORCED, CFG_INVERTED, CFG_KINDS
   } cfg_kind_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   svdsl_req_chan req_ch ();
   svdsl_rsp_chan rsp_ch ();

   servo_duty_slew_limiter uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block: register copies, current duty and the time sum.
   svdsl_cfg_type     shadow_cfg;
   logic [DUTY_W-1:0] duty_state;
   longint            time_sum;

   // Duty values still owed by the block, oldest first.
   logic [DUTY_W-1:0] pending_duty_q [$];

   // Register values the next load_regs() will write, one per index.
   csr_word_type reg_image [CSR_SLOTS];

   int fail_count    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;   // written with <= so the receiver sees it on an edge
   int hold_stamp    = 0;   // bump to request one long receiver hold-off
   int hold_seen     = 0;
   int hold_left     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block wedges; far beyond the slowest legal run.
   initial begin
      #1_600_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic void log_failure(string what, longint want, longint got);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] mismatch: %s, expected %0d, got %0d", $time, what, want, got);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Clamp to the upper limit first, then the lower one; inverted limits
   // therefore end at the lower limit.
   function automatic logic [DUTY_W-1:0] clamp_to_limits(longint v);
      if (v > longint'(shadow_cfg.duty_max_ns)) v = longint'(shadow_cfg.duty_max_ns);
      if (v < longint'(shadow_cfg.duty_min_ns)) v = longint'(shadow_cfg.duty_min_ns);
      return DUTY_W'(v);
   endfunction

   // Duty for a signed angle: gain is Q16.8, rounding is half away from zero.
   function automatic logic [DUTY_W-1:0] duty_at_angle(longint angle);
      longint span;
      longint mag;
      longint scaled;
      span   = 90 - angle;
      mag    = (span < 0) ? -span : span;
      scaled = (mag * longint'(shadow_cfg.angle_gain) + 128) >>> 8;
      if (span < 0) scaled = -scaled;
      return clamp_to_limits(scaled + longint'(shadow_cfg.duty_min_ns));
   endfunction

   // Advance the shadow by one accepted item; return 1 when a duty is emitted.
   function automatic bit predict_duty(servo_item_type it, output logic [DUTY_W-1:0] duty);
      longint speed;
      longint slew;
      longint now;
      longint goal;
      longint fang;
      duty = '0;
      if (it.action == ACT_HOME) begin
         duty_state = duty_at_angle(0);
         time_sum   = 0;
         duty       = duty_state;
         return 1'b1;
      end
      time_sum = time_sum + longint'(it.elapsed);
      if (time_sum > TIME_SAT) time_sum = TIME_SAT;
      if (time_sum < longint'(shadow_cfg.update_time_min_us)) return 1'b0;

      speed = (it.rate == '0) ? longint'(shadow_cfg.default_speed) : longint'(it.rate);
      slew  = (speed * time_sum + (longint'(1) << (SPEED_FRAC - 1))) >>> SPEED_FRAC;
      time_sum = 0;

      now  = longint'(duty_state);
      goal = now;
      if (it.dir == DIR_UP) goal = now - slew;
      else if (it.dir == DIR_DOWN) goal = now + slew;

      // Force modes override the requested direction.
      case (shadow_cfg.force_mode)
         FM_UP:    goal = now + slew;
         FM_DOWN:  goal = now - slew;
         FM_HOLD:  goal = now;
         FM_ANGLE: begin
            fang = longint'($unsigned(shadow_cfg.force_angle_deg));
            if (fang >= 256) fang = fang - 512;
            goal = longint'(duty_at_angle(fang - 20));
         end
         default: ;
      endcase

      goal = longint'(clamp_to_limits(goal));
      if (goal == now) return 1'b0;
      duty_state = DUTY_W'(goal);
      duty       = duty_state;
      return 1'b1;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, csr_word_type val);
      case (idx)
         CSR_UPDATE_TIME_MIN: shadow_cfg.update_time_min_us = val[TMIN_W-1:0];
         CSR_DEFAULT_SPEED:   shadow_cfg.default_speed      = val[RATE_W-1:0];
         CSR_DUTY_MIN:        shadow_cfg.duty_min_ns        = val[DUTY_W-1:0];
         CSR_DUTY_MAX:        shadow_cfg.duty_max_ns        = val[DUTY_W-1:0];
         CSR_ANGLE_GAIN:      shadow_cfg.angle_gain         = val[GAIN_W-1:0];
         CSR_FORCE_MODE:      shadow_cfg.force_mode         = val[FMODE_W-1:0];
         CSR_FORCE_ANGLE:     shadow_cfg.force_angle_deg    = val[FANG_W-1:0];
         default: ;   // out-of-range index: the block drops it
      endcase
   endfunction

   function automatic csr_word_type angle_word(int deg);
      logic [FANG_W-1:0] a;
      a = deg[FANG_W-1:0];
      return csr_word_type'(a);
   endfunction

   function automatic void image_defaults();
      reg_image[CSR_UPDATE_TIME_MIN] = csr_word_type'(TMIN_RESET);
      reg_image[CSR_DEFAULT_SPEED]   = csr_word_type'(SPEED_RESET);
      reg_image[CSR_DUTY_MIN]        = csr_word_type'(DUTY_MIN_RESET);
      reg_image[CSR_DUTY_MAX]        = csr_word_type'(DUTY_MAX_RESET);
      reg_image[CSR_ANGLE_GAIN]      = csr_word_type'(GAIN_RESET);
      reg_image[CSR_FORCE_MODE]      = csr_word_type'(FM_NONE);
      reg_image[CSR_FORCE_ANGLE]     = angle_word(0);
      reg_image[CSR_UNUSED]          = CSR_DATA_W'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one item and hold it until accepted. Valid stays high on return so
   // back-to-back items never drop it; settle() or an idle gap before an item lowers it.
   task automatic send_item(servo_item_type it);
      int gap;
      logic [DUTY_W-1:0] duty;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.action         <= it.action;
      req_ch.elapsed_us     <= it.elapsed;
      req_ch.move_direction <= it.dir;
      req_ch.move_rate      <= it.rate;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (predict_duty(it, duty)) pending_duty_q.push_back(duty);
   endtask

   task automatic send_tick(int elapsed, logic [DIR_W-1:0] dir, int rate);
      send_item('{action: ACT_TICK, elapsed: ELAPSED_W'(elapsed), dir: dir,
                  rate: RATE_W'(rate)});
   endtask

   // The block ignores the other fields of a home, so scramble them.
   task automatic send_home();
      send_item('{action: ACT_HOME, elapsed: ELAPSED_W'($urandom),
                  dir: DIR_W'($urandom), rate: RATE_W'($urandom)});
   endtask

   // Drop valid, wait for every owed duty, then give silent ticks time to retire.
   task automatic settle();
      int guard;
      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_duty_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write every index, the unused one included, from reg_image.
   task automatic load_regs();
      settle();
      for (int i = 0; i < CSR_SLOTS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= reg_image[i];
         @(posedge clock);
         apply_reg(CSR_INDEX_W'(i), reg_image[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off whenever hold_stamp moves.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_stamp != hold_seen) begin
            hold_seen = hold_stamp;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each accepted duty with the oldest one owed.
   always @(posedge clock) begin
      logic [DUTY_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_duty_q.size() == 0) begin
            log_failure("duty_ns with nothing owed", 0, rsp_ch.duty_ns);
         end else begin
            want = pending_duty_q.pop_front();
            if (want !== rsp_ch.duty_ns) log_failure("duty_ns", want, rsp_ch.duty_ns);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Runs on the reset register values: threshold edges, the duty held from
   // reset before any home, a home with junk fields, clamping at the lower limit,
   // stop and the spare direction code.
   task automatic test_reset_values();
      send_tick(0, DIR_DOWN, 0);
      send_tick(19999, DIR_DOWN, 0);             // one short of the threshold
      send_tick(1, DIR_DOWN, 0);                 // reaches it, moves off reset duty
      send_item('{action: ACT_HOME, elapsed: '1, dir: '1, rate: '1});
      send_tick(ELAPSED_MAX, DIR_UP, RATE_MAX);  // slam into the lower limit
      send_tick(20000, DIR_UP, 0);               // pinned, no change
      send_tick(20000, DIR_STOP, RATE_MAX);
      send_tick(20000, DIR_SPARE, RATE_MAX);     // spare code acts as stop
      send_tick(20000, DIR_DOWN, RATE_MAX);      // moves toward the upper limit
      send_tick(20000, DIR_DOWN, 0);
   endtask

   // Every force mode, including the spare codes, angle extremes and
   // inverted limits. A zero threshold lets every tick act.
   task automatic test_force_modes();
      logic [FMODE_W-1:0] modes [8] = '{FM_UP, FM_DOWN, FM_HOLD, FM_ANGLE, FM_ANGLE,
                                        FM_ANGLE, FM_SPARE_LO, FM_SPARE_HI};
      int angles [8] = '{0, 0, 0, -180, 180, 0, 0, 0};
      for (int i = 0; i < 8; i++) begin
         image_defaults();
         reg_image[CSR_UPDATE_TIME_MIN] = '0;
         reg_image[CSR_FORCE_MODE]      = csr_word_type'(modes[i]);
         reg_image[CSR_FORCE_ANGLE]     = angle_word(angles[i]);
         load_regs();
         send_home();
         // Force up is paired with an up request and force down with a down one.
         send_tick(5000, (i % 2 == 0) ? DIR_UP : DIR_DOWN, 0);
      end
      image_defaults();
      reg_image[CSR_UPDATE_TIME_MIN] = '0;
      reg_image[CSR_DUTY_MIN]        = csr_word_type'(2000000);
      reg_image[CSR_DUTY_MAX]        = csr_word_type'(1000000);
      load_regs();
      send_home();
      send_tick(5000, DIR_DOWN, 0);
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering items that all emit, so the queue fills and ready drops.
   task automatic test_backpressure();
      image_defaults();
      reg_image[CSR_UPDATE_TIME_MIN] = '0;
      load_regs();
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_stamp    <= hold_stamp + 1;
      send_home();
      for (int i = 0; i < 40; i++)
         send_tick(1000 + $urandom_range(0, 999), (i % 2 == 0) ? DIR_UP : DIR_DOWN, 0);
   endtask

   // Random traffic under every idling pattern and every register flavor.
   task automatic test_random_traffic();
      int send_pcts  [4] = '{0, 81, 0, 27};
      int stall_pcts [4] = '{0, 0, 81, 27};
      int floor_ns;
      int span;
      servo_item_type it;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         rsp_stall_pct <= stall_pcts[p];
         for (int k = 0; k < CFG_KINDS; k++) begin
            image_defaults();
            case (cfg_kind_type'(k))
               CFG_FAST: begin
                  reg_image[CSR_UPDATE_TIME_MIN] = csr_word_type'($urandom_range(0, 3));
                  reg_image[CSR_DEFAULT_SPEED]   = csr_word_type'(RATE_W'($urandom));
                  floor_ns = $urandom_range(0, 1500000);
                  reg_image[CSR_DUTY_MIN]   = csr_word_type'(floor_ns);
                  reg_image[CSR_DUTY_MAX]   =
                     csr_word_type'(floor_ns + $urandom_range(0, 1500000));
                  reg_image[CSR_ANGLE_GAIN] = csr_word_type'($urandom_range(0, 1 << 22));
               end
               CFG_SLOW: begin
                  // Maximum threshold: the time sum has to saturate to act.
                  reg_image[CSR_UPDATE_TIME_MIN] = csr_word_type'(TIME_SAT);
                  reg_image[CSR_DEFAULT_SPEED]   = csr_word_type'(RATE_MAX);
                  reg_image[CSR_DUTY_MIN]        = '0;
                  reg_image[CSR_DUTY_MAX]        = '1;
                  reg_image[CSR_ANGLE_GAIN]      = csr_word_type'({GAIN_W{1'b1}});
               end
               CFG_SCRAMBLED: begin
                  // Full-width junk, upper bits above each register included.
                  for (int r = 0; r < CSR_SLOTS; r++) reg_image[r] = CSR_DATA_W'($urandom);
                  reg_image[CSR_UPDATE_TIME_MIN] =
                     {1'($urandom), TMIN_W'($urandom_range(0, 100000))};
               end
               CFG_FORCED: begin
                  reg_image[CSR_UPDATE_TIME_MIN] = csr_word_type'($urandom_range(0, 30000));
                  reg_image[CSR_FORCE_MODE] =
                     csr_word_type'($urandom_range(int'(FM_UP), int'(FM_ANGLE)));
                  case ($urandom_range(3))
                     0:       reg_image[CSR_FORCE_ANGLE] = angle_word(-180);
                     1:       reg_image[CSR_FORCE_ANGLE] = angle_word(180);
                     default: reg_image[CSR_FORCE_ANGLE] =
                                 angle_word(int'($urandom_range(0, 360)) - 180);
                  endcase
               end
               CFG_INVERTED: begin
                  reg_image[CSR_UPDATE_TIME_MIN] = csr_word_type'($urandom_range(0, 5000));
                  reg_image[CSR_DEFAULT_SPEED]   = csr_word_type'(RATE_W'($urandom));
                  floor_ns = $urandom_range(1000, (1 << DUTY_W) - 1);
                  reg_image[CSR_DUTY_MIN] = csr_word_type'(floor_ns);
                  reg_image[CSR_DUTY_MAX] = csr_word_type'($urandom_range(0, floor_ns - 1));
               end
               default: ;   // reset values
            endcase
            load_regs();

            // Mostly ticks sized around the threshold so the duty keeps moving.
            for (int n = 0; n < RANDOM_PER_CFG; n++) begin
               span = int'(shadow_cfg.update_time_min_us);
               span = span + span / 2 + 2000;
               if (span > ELAPSED_MAX) span = ELAPSED_MAX;
               it.action = ($urandom_range(99) < 8) ? ACT_HOME : ACT_TICK;
               case ($urandom_range(9))
                  0:       it.elapsed = '0;
                  1:       it.elapsed = '1;
                  2:       it.elapsed = ELAPSED_W'($urandom);
                  default: it.elapsed = ELAPSED_W'($urandom_range(0, span));
               endcase
               it.dir = DIR_W'($urandom_range(3));
               case ($urandom_range(7))
                  0, 1:    it.rate = '0;      // falls back to the default speed
                  2:       it.rate = '1;
                  3:       it.rate = RATE_W'($urandom);
                  default: it.rate = RATE_W'($urandom_range(1, 1 << 18));
               endcase
               send_item(it);
            end
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.action         = '0;
      req_ch.elapsed_us     = '0;
      req_ch.move_direction = '0;
      req_ch.move_rate      = '0;

      // Shadow starts from the register reset values; duty sits at the
      // default lower limit, as the block's reset leaves it.
      shadow_cfg.update_time_min_us = TMIN_RESET;
      shadow_cfg.default_speed      = SPEED_RESET;
      shadow_cfg.duty_min_ns        = DUTY_MIN_RESET;
      shadow_cfg.duty_max_ns        = DUTY_MAX_RESET;
      shadow_cfg.angle_gain         = GAIN_RESET;
      shadow_cfg.force_mode         = FM_NONE;
      shadow_cfg.force_angle_deg    = '0;
      duty_state = DUTY_MIN_RESET;
      time_sum   = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_force_modes();
      test_backpressure();
      test_random_traffic();

      settle();
      if (pending_duty_q.size() != 0)
         log_failure("duty items never delivered", pending_duty_q.size(), 0);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
